>>> src/ssc_pkg.sv
// Package for the syndrome sync checker: masks, counter limits and widths.
// No dependencies; imported by ssc_nibble_step and syndrome_sync_check.
`default_nettype none

package ssc_pkg;

    // Largest block the counters are sized for
    localparam int MAX_BLOCK_BYTES = 4096;

    // Field and state widths
    localparam int WIN_W   = 28;
    localparam int CNT_W   = 14;
    localparam int BCNT_W  = 13;
    localparam int NIB_W   = 4;

    // Syndrome counters stop at the smaller of twice the block size and the counter span
    localparam int COUNT_LIMIT_I = (2 * MAX_BLOCK_BYTES > 16383) ? 16383 : 2 * MAX_BLOCK_BYTES;
    localparam logic [CNT_W-1:0]  COUNT_LIMIT  = COUNT_LIMIT_I[CNT_W-1:0];
    localparam logic [BCNT_W-1:0] BYTE_CNT_MAX = {BCNT_W{1'b1}};

    // Parity masks for the two code variants
    localparam logic [WIN_W-1:0] SYND_MASK_A = 28'hFB536D3;
    localparam logic [WIN_W-1:0] SYND_MASK_B = 28'hF7A39E3;

    // Block length that uses the looser threshold
    localparam logic [BCNT_W-1:0] SHORT_BLOCK_LEN = 13'd30;

    // Ratio factors; product of a saturated count and factor fits in PROD_W bits
    localparam int PROD_W = 21;
    localparam logic [PROD_W-1:0] FACTOR_SHORT = 21'd10;
    localparam logic [PROD_W-1:0] FACTOR_LONG  = 21'd100;

endpackage

`default_nettype wire

>>> src/ssc_nibble_step.sv
// One nibble step of the syndrome check: shift the window, take the masked parity.
// Depends on ssc_pkg.
`default_nettype none

module ssc_nibble_step
    import ssc_pkg::*;
(
    input  wire logic [WIN_W-1:0] i_window,
    input  wire logic [NIB_W-1:0] i_nibble,
    input  wire logic             i_use_mask_b,
    output logic      [WIN_W-1:0] o_window,
    output logic                  o_syndrome
);

    logic [WIN_W-1:0] mask;

    // Shift the nibble in at the low end
    assign o_window = {i_window[WIN_W-NIB_W-1:0], i_nibble};

    // Syndrome bit is the parity of the masked window
    assign mask       = i_use_mask_b ? SYND_MASK_B : SYND_MASK_A;
    assign o_syndrome = ^(o_window & mask);

endmodule

`default_nettype wire

>>> src/syndrome_sync_check.sv
// Top level of the syndrome sync checker: input register, state update, result register.
// Depends on ssc_pkg and ssc_nibble_step.
`default_nettype none

//  channel | handshake                     | beat
//  --------+-------------------------------+----------------------------------------
//  input   | i_in_valid / o_in_stall       | i_data_byte, i_use_mask_b, i_last_byte
//  output  | o_out_valid / i_out_stall     | o_in_sync, o_zero_count, o_one_count
//
// One byte per cycle while o_in_stall is low. A beat is captured in the input register at
// acceptance; its two nibble steps, counter updates and the sync decision complete when it leaves
// that register, and the result of a last byte is then written to the output register.
// Reset (synchronous, active low) empties both registers and closes any open block.
// Input is stalled only while a last-byte beat waits and the output register is still held.

module syndrome_sync_check
    import ssc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_use_mask_b,
    input  wire logic              i_last_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_in_sync,
    output logic      [CNT_W-1:0]  o_zero_count,
    output logic      [CNT_W-1:0]  o_one_count
);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_data;
    logic              r_selb;
    logic              r_last;

    // block state
    logic [WIN_W-1:0]  r_window;
    logic [CNT_W-1:0]  r_zero;
    logic [CNT_W-1:0]  r_one;
    logic [BCNT_W-1:0] r_bytes;
    logic              r_variant;
    logic              r_open;

    logic [WIN_W-1:0]  n_window;
    logic [CNT_W-1:0]  n_zero;
    logic [CNT_W-1:0]  n_one;
    logic [BCNT_W-1:0] n_bytes;
    logic              n_in_sync;

    logic              advance;
    logic              accept;
    logic [WIN_W-1:0]  base_window;
    logic [CNT_W-1:0]  base_zero;
    logic [CNT_W-1:0]  base_one;
    logic [BCNT_W-1:0] base_bytes;
    logic              variant;
    logic [WIN_W-1:0]  mid_window;
    logic              synd0;
    logic              synd1;
    logic [1:0]        ones_add;
    logic [1:0]        zeros_add;
    logic [CNT_W:0]    zero_sum;
    logic [CNT_W:0]    one_sum;
    logic [PROD_W-1:0] factor;
    logic [PROD_W-1:0] one_scaled;

    // Handshake: the held beat moves on unless its result would overwrite a held result
    assign advance    = r_in_valid && (!r_last || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // A closed block starts fresh from this beat
    assign base_window = r_open ? r_window  : '0;
    assign base_zero   = r_open ? r_zero    : '0;
    assign base_one    = r_open ? r_one     : '0;
    assign base_bytes  = r_open ? r_bytes   : '0;
    assign variant     = r_open ? r_variant : r_selb;

    // Two nibble steps, low nibble first
    ssc_nibble_step u_step_lo (
        .i_window     (base_window),
        .i_nibble     (r_data[3:0]),
        .i_use_mask_b (variant),
        .o_window     (mid_window),
        .o_syndrome   (synd0)
    );

    ssc_nibble_step u_step_hi (
        .i_window     (mid_window),
        .i_nibble     (r_data[7:4]),
        .i_use_mask_b (variant),
        .o_window     (n_window),
        .o_syndrome   (synd1)
    );

    // Saturating counters; counts never exceed the limit, so a clamp of the sum suffices
    always_comb begin
        ones_add  = {1'b0, synd0} + {1'b0, synd1};
        zeros_add = 2'd2 - ones_add;
        zero_sum  = {1'b0, base_zero} + {{(CNT_W-1){1'b0}}, zeros_add};
        one_sum   = {1'b0, base_one}  + {{(CNT_W-1){1'b0}}, ones_add};
        n_zero    = (zero_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : zero_sum[CNT_W-1:0];
        n_one     = (one_sum  > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : one_sum[CNT_W-1:0];
        n_bytes   = (base_bytes == BYTE_CNT_MAX) ? base_bytes : base_bytes + 1'b1;
    end

    // Sync decision: ones scaled by the threshold factor against zeros
    always_comb begin
        factor     = (n_bytes == SHORT_BLOCK_LEN) ? FACTOR_SHORT : FACTOR_LONG;
        one_scaled = (n_one[6:0] == 7'd0 && n_one[CNT_W-1:7] == '0) ? '0 :
                     (factor == FACTOR_SHORT)
                         ? ({{(PROD_W-CNT_W-3){1'b0}}, n_one, 3'b000}
                            + {{(PROD_W-CNT_W-1){1'b0}}, n_one, 1'b0})
                         : ({n_one, 7'b0} - {{(PROD_W-CNT_W-5){1'b0}}, n_one, 5'b0}
                            + {{(PROD_W-CNT_W-2){1'b0}}, n_one, 2'b0});
        n_in_sync  = (n_zero != '0) &&
                     (one_scaled <= {{(PROD_W-CNT_W){1'b0}}, n_zero});
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
            r_selb <= i_use_mask_b;
            r_last <= i_last_byte;
        end
    end

    // Block state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (advance) begin
            r_open <= !r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_window  <= n_window;
            r_zero    <= n_zero;
            r_one     <= n_one;
            r_bytes   <= n_bytes;
            r_variant <= variant;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            o_in_sync    <= n_in_sync;
            o_zero_count <= n_zero;
            o_one_count  <= n_one;
        end
    end

endmodule

`default_nettype wire
